[src/dca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor chain allocator package
// Pool size, index and count widths, request and register codes.
// ----------------------------------------------------------------------------
package dca_pkg;

    localparam int DESC_NUM = 64;
    localparam int IDX_W    = $clog2(DESC_NUM);
    localparam int CNT_W    = $clog2(DESC_NUM + 1);
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    // free-list terminator
    localparam t_cnt LINK_NONE = t_cnt'(DESC_NUM);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_POOL_SIZE = 1'b0;

endpackage

[src/dca_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor chain allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dca_req_if import dca_pkg::*; ();
    logic valid;
    logic ready;
    logic func;
    t_cnt count;
    t_idx chain_head;

    modport source (output valid, func, count, chain_head, input ready);
    modport sink   (input valid, func, count, chain_head, output ready);
endinterface

interface dca_rsp_if import dca_pkg::*; ();
    logic valid;
    logic ready;
    logic ok;
    t_idx head_index;
    t_cnt free_count;

    modport source (output valid, ok, head_index, free_count, input ready);
    modport sink   (input valid, ok, head_index, free_count, output ready);
endinterface

[src/descriptor_chain_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor chain allocator
// Linked free list of queue descriptors: allocates chains from the list front
// and walks chains back onto it, one descriptor per cycle.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  i_req     in    valid/ready      func, count, chain_head
//  o_res     out   valid/ready      ok, head_index, free_count
//  apb       in    psel/penable     pool size at byte address 0
//
//  Allocate pops n descriptors off the list front, then ends the chain;
//  free pushes an n-long chain back; refused requests skip the walk. The
//  walk runs one descriptor per cycle via the registered link memory read.
//  Reset and a pool size write rebuild the list at once (per-entry
//  valid bits stand in for the rebuilt link values).
//  i_req is taken only while the sequencer is idle; a result held by a
//  stalled o_res holds the sequencer before the next transfer.
// ----------------------------------------------------------------------------
module descriptor_chain_allocator import dca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dca_req_if.sink           i_req,
    dca_rsp_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_A_STEP = 3'd1;
    localparam logic [2:0] ST_A_LAST = 3'd2;
    localparam logic [2:0] ST_F_STEP = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // control state
    logic [2:0]          r_state, n_state;
    t_cnt                r_qsize, n_qsize;
    t_cnt                r_head, n_head;
    t_cnt                r_total, n_total;
    logic [DESC_NUM-1:0] r_in_use, n_in_use;
    logic [DESC_NUM-1:0] r_link_vld, n_link_vld;
    logic                r_out_vld, n_out_vld;

    // payload
    t_cnt                r_left, n_left;
    logic                r_first, n_first;
    t_idx                r_prev, n_prev;
    t_idx                r_chain_head, n_chain_head;
    t_idx                r_cur, n_cur;
    logic                r_ok, n_ok;
    t_idx                r_res_head, n_res_head;
    logic                r_out_ok, n_out_ok;
    t_idx                r_out_head, n_out_head;
    t_cnt                r_out_free, n_out_free;

    // memories
    t_cnt                m_link  [DESC_NUM];
    logic [IDX_W:0]      m_chain [DESC_NUM];
    t_cnt                r_link_rd;
    logic                r_link_rd_vld;
    t_idx                r_link_rd_addr;
    logic [IDX_W:0]      r_chain_rd;

    logic                link_we;
    t_idx                link_wa;
    t_idx                link_ra;
    logic                chain_we;
    t_idx                chain_wa;
    logic [IDX_W:0]      chain_wd;
    t_idx                chain_ra;

    t_cnt                link_dflt;
    t_cnt                link_eff;
    logic                chain_more;
    t_idx                chain_nxt;
    logic                walk_on;
    logic                out_free;
    logic                cfg_we;
    t_cnt                cfg_size;
    t_cnt                wr_val;

    // unwritten link entries read as the rebuilt list: i -> i+1, last in the pool -> none
    assign link_dflt = (t_cnt'(r_link_rd_addr) == r_qsize - t_cnt'(1)) ? LINK_NONE
                     : t_cnt'(r_link_rd_addr) + t_cnt'(1);
    assign link_eff  = r_link_rd_vld ? r_link_rd : link_dflt;

    assign chain_more = r_chain_rd[IDX_W];
    assign chain_nxt  = r_chain_rd[IDX_W-1:0];
    // stop at a link to a descriptor not in use, including the one freed now
    assign walk_on    = chain_more && r_in_use[chain_nxt] && (chain_nxt != r_cur);

    assign link_ra  = (r_state == ST_A_STEP) ? link_eff[IDX_W-1:0] : r_head[IDX_W-1:0];
    assign chain_ra = (r_state == ST_F_STEP) ? chain_nxt : i_req.chain_head;

    assign out_free    = !r_out_vld || o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    assign o_res.valid      = r_out_vld;
    assign o_res.ok         = r_out_ok;
    assign o_res.head_index = r_out_head;
    assign o_res.free_count = r_out_free;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE);
    assign wr_val = pwdata[CNT_W-1:0];
    always_comb begin
        if (wr_val == '0) begin
            cfg_size = t_cnt'(1);
        end else if (wr_val > t_cnt'(DESC_NUM)) begin
            cfg_size = t_cnt'(DESC_NUM);
        end else begin
            cfg_size = wr_val;
        end
    end
    assign prdata = (paddr[2] == REG_POOL_SIZE) ? APB_DW'(r_qsize) : '0;

    always_comb begin
        n_state      = r_state;
        n_qsize      = r_qsize;
        n_head       = r_head;
        n_total      = r_total;
        n_in_use     = r_in_use;
        n_link_vld   = r_link_vld;
        n_left       = r_left;
        n_first      = r_first;
        n_prev       = r_prev;
        n_chain_head = r_chain_head;
        n_cur        = r_cur;
        n_ok         = r_ok;
        n_res_head   = r_res_head;
        n_out_vld    = r_out_vld;
        n_out_ok     = r_out_ok;
        n_out_head   = r_out_head;
        n_out_free   = r_out_free;
        link_we      = 1'b0;
        link_wa      = r_cur;
        chain_we     = 1'b0;
        chain_wa     = r_prev;
        chain_wd     = '0;

        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.func == FUNC_ALLOC) begin
                        if (i_req.count == '0 || i_req.count > r_total) begin
                            n_ok       = 1'b0;
                            n_res_head = '0;
                            n_state    = ST_DONE;
                        end else begin
                            n_left  = i_req.count;
                            n_first = 1'b1;
                            n_state = ST_A_STEP;
                        end
                    end else begin
                        if (!r_in_use[i_req.chain_head]) begin
                            n_ok       = 1'b0;
                            n_res_head = '0;
                            n_state    = ST_DONE;
                        end else begin
                            n_cur   = i_req.chain_head;
                            n_state = ST_F_STEP;
                        end
                    end
                end
            end
            ST_A_STEP: begin
                // pop the list front and hook it behind the previous one
                n_in_use[r_head[IDX_W-1:0]] = 1'b1;
                n_total = r_total - t_cnt'(1);
                n_head  = link_eff;
                n_prev  = r_head[IDX_W-1:0];
                n_first = 1'b0;
                n_left  = r_left - t_cnt'(1);
                if (r_first) begin
                    n_chain_head = r_head[IDX_W-1:0];
                end else begin
                    chain_we = 1'b1;
                    chain_wa = r_prev;
                    chain_wd = {1'b1, r_head[IDX_W-1:0]};
                end
                if (r_left == t_cnt'(1)) begin
                    n_state = ST_A_LAST;
                end
            end
            ST_A_LAST: begin
                // terminate the chain
                chain_we   = 1'b1;
                chain_wa   = r_prev;
                chain_wd   = '0;
                n_ok       = 1'b1;
                n_res_head = r_chain_head;
                n_state    = ST_DONE;
            end
            ST_F_STEP: begin
                // push the current descriptor onto the list front
                link_we              = 1'b1;
                link_wa              = r_cur;
                n_link_vld[r_cur]    = 1'b1;
                n_in_use[r_cur]      = 1'b0;
                n_head               = t_cnt'(r_cur);
                n_total              = r_total + t_cnt'(1);
                if (walk_on) begin
                    n_cur = chain_nxt;
                end else begin
                    n_ok       = 1'b1;
                    n_res_head = '0;
                    n_state    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_ok   = r_ok;
                    n_out_head = r_res_head;
                    n_out_free = r_total;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // rebuild the free list in index order
        if (cfg_we) begin
            n_qsize    = cfg_size;
            n_head     = '0;
            n_total    = cfg_size;
            n_in_use   = '0;
            n_link_vld = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_qsize    <= t_cnt'(DESC_NUM);
            r_head     <= '0;
            r_total    <= t_cnt'(DESC_NUM);
            r_in_use   <= '0;
            r_link_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_qsize    <= n_qsize;
            r_head     <= n_head;
            r_total    <= n_total;
            r_in_use   <= n_in_use;
            r_link_vld <= n_link_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_first      <= n_first;
        r_prev       <= n_prev;
        r_chain_head <= n_chain_head;
        r_cur        <= n_cur;
        r_ok         <= n_ok;
        r_res_head   <= n_res_head;
        r_out_ok     <= n_out_ok;
        r_out_head   <= n_out_head;
        r_out_free   <= n_out_free;
    end

    // free-link memory
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            m_link[link_wa] <= r_head;
        end
        r_link_rd      <= m_link[link_ra];
        r_link_rd_vld  <= r_link_vld[link_ra];
        r_link_rd_addr <= link_ra;
    end

    // chain link memory
    always_ff @(posedge i_clk) begin
        if (chain_we) begin
            m_chain[chain_wa] <= chain_wd;
        end
        r_chain_rd <= m_chain[chain_ra];
    end

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_qsize)
        else $error("free count above pool size");

    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_in_use) + int'(r_total)) == int'(r_qsize))
        else $error("descriptors in use and free do not add up to pool size");

    a_walk_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_STEP) |-> r_in_use[r_cur])
        else $error("free walk reached a descriptor not in use");

    a_alloc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_A_STEP) |-> (r_head < t_cnt'(DESC_NUM)))
        else $error("allocation popped an empty free list");

endmodule
